>>> hdl/sap_pkg.sv
// Shared types and constants for the separating-axis penetration block.
package sap_pkg;

  localparam int CoordW  = 16;
  localparam int AxisW   = 16;
  localparam int ProdW   = CoordW + AxisW;
  localparam int ProjW   = 34;
  localparam int PenW    = 33;
  localparam int CfgIdxW = 2;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_FIRST_PT  = 2'd0,
    OP_SECOND_PT = 2'd1,
    OP_FIRST_CTR = 2'd2,
    OP_FINISH    = 2'd3
  } sap_op_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_AXIS_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_AXIS_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_AXIS_Z = 2'd2;

  localparam logic signed [AxisW-1:0] AXIS_X_RST = 16'sd16384;
  localparam logic signed [AxisW-1:0] AXIS_Y_RST = 16'sd0;
  localparam logic signed [AxisW-1:0] AXIS_Z_RST = 16'sd0;

  typedef logic signed [ProjW-1:0] sap_proj_t;

  localparam sap_proj_t PROJ_MAX = {1'b0, {(ProjW-1){1'b1}}};
  localparam sap_proj_t PROJ_MIN = {1'b1, {(ProjW-1){1'b0}}};

  typedef struct packed {
    sap_op_t                   op;
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
    logic signed [CoordW-1:0]  z;
  } sap_in_t;

  typedef struct packed {
    logic [PenW-1:0] penetration;
    logic            separated;
    logic            empty_set;
  } sap_out_t;

  typedef struct packed {
    logic signed [AxisW-1:0] ax;
    logic signed [AxisW-1:0] ay;
    logic signed [AxisW-1:0] az;
  } sap_axis_t;

  // Pipeline control token
  typedef struct packed {
    logic    vld;
    sap_op_t op;
  } sap_tok_t;

endpackage

>>> hdl/sap_proj.sv
// Two-stage projection pipeline: per-axis products, then their sum.
module sap_proj import sap_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  sap_in_t   in_data,
  input  sap_axis_t axis,
  output sap_tok_t  tok,
  output sap_proj_t proj
);

  sap_tok_t                tok_a_r;
  sap_tok_t                tok_b_r;
  logic signed [ProdW-1:0] px_r;
  logic signed [ProdW-1:0] py_r;
  logic signed [ProdW-1:0] pz_r;
  sap_proj_t               proj_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r <= '0;
      tok_b_r <= '0;
    end else if (adv) begin
      tok_a_r <= '{vld: in_vld, op: in_data.op};
      tok_b_r <= tok_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r   <= axis.ax * in_data.x;
      py_r   <= axis.ay * in_data.y;
      pz_r   <= axis.az * in_data.z;
      proj_r <= sap_proj_t'(px_r) + sap_proj_t'(py_r) + sap_proj_t'(pz_r);
    end
  end

  assign tok  = tok_b_r;
  assign proj = proj_r;

endmodule

>>> hdl/sap_track.sv
// Running min/max per set, first center, and the penetration result.
module sap_track import sap_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  sap_tok_t  tok,
  input  sap_proj_t proj,
  output logic      res_vld,
  output sap_out_t  res
);

  sap_proj_t first_min_r;
  sap_proj_t first_max_r;
  sap_proj_t second_min_r;
  sap_proj_t second_max_r;
  sap_proj_t ctr_r;
  logic      first_seen_r;
  logic      second_seen_r;

  logic                 fire;
  logic                 empty;
  logic                 sep;
  logic signed [ProjW:0] minu;
  logic signed [ProjW:0] subt;
  logic signed [ProjW:0] diff;

  assign fire = tok.vld && adv;

  always_comb begin
    empty = !first_seen_r || !second_seen_r;
    sep   = !empty && ((first_max_r <= second_min_r) || (first_min_r >= second_max_r));
    // first center below second: max1 - min2, else max2 - min1
    if (ctr_r < proj) begin
      minu = (ProjW+1)'(first_max_r);
      subt = (ProjW+1)'(second_min_r);
    end else begin
      minu = (ProjW+1)'(second_max_r);
      subt = (ProjW+1)'(first_min_r);
    end
    diff = minu - subt;
    res.penetration = (empty || sep) ? '0 : diff[PenW-1:0];
    res.separated   = sep;
    res.empty_set   = empty;
  end

  assign res_vld = fire && (tok.op == OP_FINISH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_min_r   <= PROJ_MAX;
      first_max_r   <= PROJ_MIN;
      second_min_r  <= PROJ_MAX;
      second_max_r  <= PROJ_MIN;
      ctr_r         <= '0;
      first_seen_r  <= 1'b0;
      second_seen_r <= 1'b0;
    end else if (fire) begin
      case (tok.op)
        OP_FIRST_PT: begin
          if (proj < first_min_r) first_min_r <= proj;
          if (proj > first_max_r) first_max_r <= proj;
          first_seen_r <= 1'b1;
        end
        OP_SECOND_PT: begin
          if (proj < second_min_r) second_min_r <= proj;
          if (proj > second_max_r) second_max_r <= proj;
          second_seen_r <= 1'b1;
        end
        OP_FIRST_CTR: begin
          ctr_r <= proj;
        end
        default: begin
          first_min_r   <= PROJ_MAX;
          first_max_r   <= PROJ_MIN;
          second_min_r  <= PROJ_MAX;
          second_max_r  <= PROJ_MIN;
          ctr_r         <= '0;
          first_seen_r  <= 1'b0;
          second_seen_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> hdl/separating_axis_penetration.sv
// Top level of the separating-axis penetration block.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | input     | in_valid / in_stall  | sap_in_t  (op, x, y, z)
//  out_    | output    | out_valid / out_stall| sap_out_t (penetration, flags)
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (axis)
//
// One transaction per cycle in while in_stall is low; a finish transaction's result
// passes through the product stage (loaded on acceptance), then the sum stage,
// then the result register.
// Points and centers keep flowing while a result waits; only a second finish
// reaching the tracker while the result register is stalled holds the pipe.
// Reset (rst_n low, synchronous) restores the axis to (1.0, 0, 0) and empties
// the pipeline and the per-set state. Config writes are always ready.
module separating_axis_penetration import sap_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // item input
  input  logic                in_valid,
  output logic                in_stall,
  input  sap_in_t             in_data,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output sap_out_t            out_data,
  // axis configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [AxisW-1:0]    cfg_data
);

  sap_axis_t axis_r;
  sap_tok_t  tok;
  sap_proj_t proj;
  logic      adv;
  logic      res_vld;
  sap_out_t  res;
  logic      out_valid_r;
  sap_out_t  out_data_r;

  // axis registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '{ax: AXIS_X_RST, ay: AXIS_Y_RST, az: AXIS_Z_RST};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AXIS_X: axis_r.ax <= cfg_data;
        REG_AXIS_Y: axis_r.ay <= cfg_data;
        REG_AXIS_Z: axis_r.az <= cfg_data;
        default:    ;
      endcase
    end
  end

  // whole pipe advances unless a finish would overwrite a stalled result
  assign adv      = !(tok.vld && (tok.op == OP_FINISH) && out_valid_r && out_stall);
  assign in_stall = !adv;

  sap_proj u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .in_data (in_data),
    .axis    (axis_r),
    .tok     (tok),
    .proj    (proj)
  );

  sap_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .tok     (tok),
    .proj    (proj),
    .res_vld (res_vld),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/sap_chk.sv
// Port-level checker for the separating-axis penetration block, with bind.
module sap_chk import sap_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sap_out_t           out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input only backs up behind a stalled result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled without pending result");

  // flags are exclusive
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.separated && out_data.empty_set))
    else $error("separated and empty_set both set");

  // no depth reported when separated or empty
  a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.separated || out_data.empty_set) |-> out_data.penetration == '0)
    else $error("nonzero depth with separated or empty set");

endmodule

bind separating_axis_penetration sap_chk u_sap_chk (.*);
